// ===== src/grwi_pkg.sv =====
// Shared types, constants and the arctangent table of the grid ray caster.
package grwi_pkg;

  localparam int CW            = 20;
  localparam int WW            = 48;
  localparam int CNT_W         = 6;
  localparam int CORDIC_ITERS  = 20;
  localparam int DIV_ITERS     = 48;
  localparam int SQRT_ITERS    = 21;
  localparam int SQ_W          = 42;
  localparam int DIST_W        = 22;

  localparam logic [14:0] FULL_TURN = 15'd23040;
  localparam logic [14:0] ANG_90    = 15'd5760;
  localparam logic [14:0] ANG_180   = 15'd11520;
  localparam logic [14:0] ANG_270   = 15'd17280;
  localparam logic [14:0] SNAP_TOL  = 15'd63;

  typedef enum logic [1:0] {
    OP_CORDIC,
    OP_DIV,
    OP_SQRT,
    OP_MUL
  } grwi_op_e;

  typedef struct packed {
    logic [WW-1:0] a;
    logic [WW-1:0] b;
    logic [WW-1:0] c;
  } grwi_work_t;

  function automatic logic [19:0] atan_rom(input logic [4:0] i);
    logic [19:0] v;
    case (i)
      5'd0:    v = 20'd737280;
      5'd1:    v = 20'd435242;
      5'd2:    v = 20'd229970;
      5'd3:    v = 20'd116736;
      5'd4:    v = 20'd58595;
      5'd5:    v = 20'd29326;
      5'd6:    v = 20'd14667;
      5'd7:    v = 20'd7334;
      5'd8:    v = 20'd3667;
      5'd9:    v = 20'd1833;
      5'd10:   v = 20'd917;
      5'd11:   v = 20'd458;
      5'd12:   v = 20'd229;
      5'd13:   v = 20'd115;
      5'd14:   v = 20'd57;
      5'd15:   v = 20'd29;
      5'd16:   v = 20'd14;
      5'd17:   v = 20'd7;
      5'd18:   v = 20'd4;
      5'd19:   v = 20'd2;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/grwi_step_unit.sv =====
// Shared arithmetic step: CORDIC rotation, divide step, square root step or multiply.
module grwi_step_unit (
  input  grwi_pkg::grwi_op_e   op_i,
  input  logic [4:0]           iter_i,
  input  grwi_pkg::grwi_work_t cur_i,
  output grwi_pkg::grwi_work_t nxt_o
);

  localparam int WW = grwi_pkg::WW;

  logic [WW-1:0]        sh;
  logic [WW-1:0]        trial;
  logic [WW-1:0]        diff;
  logic                 ge;
  logic signed [WW-1:0] x;
  logic signed [WW-1:0] y;
  logic signed [WW-1:0] z;
  logic signed [WW-1:0] xs;
  logic signed [WW-1:0] ys;
  logic signed [WW-1:0] at;
  logic [55:0]          prod;

  // The divider and the square root share one compare and subtract.
  assign sh    = (op_i == grwi_pkg::OP_SQRT) ? {cur_i.a[WW-3:0], cur_i.b[WW-1:WW-2]}
                                             : {cur_i.a[WW-2:0], cur_i.b[WW-1]};
  assign trial = (op_i == grwi_pkg::OP_SQRT) ? {cur_i.c[WW-3:0], 2'b01} : cur_i.c;
  assign ge    = (sh >= trial);
  assign diff  = sh - trial;

  assign x    = $signed(cur_i.a);
  assign y    = $signed(cur_i.b);
  assign z    = $signed(cur_i.c);
  assign xs   = x >>> iter_i;
  assign ys   = y >>> iter_i;
  assign at   = $signed(WW'(grwi_pkg::atan_rom(iter_i)));
  assign prod = cur_i.a[23:0] * cur_i.b[31:0];

  always_comb begin
    nxt_o = cur_i;
    unique case (op_i)
      grwi_pkg::OP_CORDIC: begin
        if (!z[WW-1]) begin
          nxt_o.a = $unsigned(x - ys);
          nxt_o.b = $unsigned(y + xs);
          nxt_o.c = $unsigned(z - at);
        end else begin
          nxt_o.a = $unsigned(x + ys);
          nxt_o.b = $unsigned(y - xs);
          nxt_o.c = $unsigned(z + at);
        end
      end
      grwi_pkg::OP_DIV: begin
        nxt_o.a = ge ? diff : sh;
        nxt_o.b = {cur_i.b[WW-2:0], ge};
      end
      grwi_pkg::OP_SQRT: begin
        nxt_o.a = ge ? diff : sh;
        nxt_o.b = {cur_i.b[WW-3:0], 2'b00};
        nxt_o.c = {cur_i.c[WW-2:0], ge};
      end
      grwi_pkg::OP_MUL: begin
        nxt_o.a = prod[WW-1:0];
      end
      default: nxt_o = cur_i;
    endcase
  end

endmodule

// ===== src/grid_ray_wall_intersection.sv =====
// Top level of the grid ray caster: sequencer, crossing registers and handshakes.
// One ray runs 20 CORDIC rotations and up to three divisions on the shared step unit
// for its setup, followed by at most MAX_STEPS tile steps; each step needs up to two
// distance evaluations, one when the ray is axis-aligned.
// Snapped angles skip the CORDIC and the tangent division. One ray is in flight at a time.
// Reset clears the map register to all walls and empties the output register.
module grid_ray_wall_intersection #(
  parameter int TILE_SHIFT = 6,
  parameter int MAP_SIDE   = 8,
  parameter int MAX_STEPS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] open_map_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [8:0]  player_x_i,
  input  logic [8:0]  player_y_i,
  input  logic [14:0] ray_angle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [8:0]  hit_x_o,
  output logic [8:0]  hit_y_o,
  output logic        wall_found_o
);

  localparam int CW     = grwi_pkg::CW;
  localparam int WW     = grwi_pkg::WW;
  localparam int CNT_W  = grwi_pkg::CNT_W;
  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int HI_RAW = MAP_SIDE * (1 << TILE_SHIFT) - 1;
  localparam int HI     = (HI_RAW > 511) ? 511 : HI_RAW;
  localparam logic signed [CW-1:0] TILE_C  = CW'(64'(1) << TILE_SHIFT);
  localparam logic signed [CW-1:0] NEG_ONE = '1;
  localparam logic signed [CW-1:0] HI_C    = CW'(HI);
  localparam logic [STEP_W-1:0]    LAST_STEP = STEP_W'(MAX_STEPS - 1);
  localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(grwi_pkg::CORDIC_ITERS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(grwi_pkg::DIV_ITERS - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(grwi_pkg::SQRT_ITERS - 1);

  typedef enum logic [19:0] {
    S_IDLE   = 20'b00000000000000000001,
    S_CORD   = 20'b00000000000000000010,
    S_TCHK   = 20'b00000000000000000100,
    S_TDIV   = 20'b00000000000000001000,
    S_TSAT   = 20'b00000000000000010000,
    S_HX     = 20'b00000000000000100000,
    S_HDIV   = 20'b00000000000001000000,
    S_VMUL   = 20'b00000000000010000000,
    S_VYS    = 20'b00000000000100000000,
    S_HDXS   = 20'b00000000001000000000,
    S_HDXD   = 20'b00000000010000000000,
    S_HDXF   = 20'b00000000100000000000,
    S_DSTART = 20'b00000001000000000000,
    S_DSQX   = 20'b00000010000000000000,
    S_DSQY   = 20'b00000100000000000000,
    S_DSQRT  = 20'b00001000000000000000,
    S_FIRST  = 20'b00010000000000000000,
    S_STEP   = 20'b00100000000000000000,
    S_PICK   = 20'b01000000000000000000,
    S_OUT    = 20'b10000000000000000000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  grwi_pkg::grwi_work_t ws_q, ws_d, unit_in, unit_out;
  grwi_pkg::grwi_op_e unit_op;
  logic [63:0] open_map_q;
  logic [8:0]  px_q, px_d, py_q, py_d;
  logic        down_q, down_d, left_q, left_d, hoff_q, hoff_d, voff_q, voff_d;
  logic [31:0] tq_q, tq_d;
  logic signed [CW-1:0] hx_q, hx_d, hy_q, hy_d, vx_q, vx_d, vy_q, vy_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [CW-1:0] hdx_q, hdx_d;
  logic [grwi_pkg::SQ_W-1:0] sq_q, sq_d;
  logic [grwi_pkg::DIST_W-1:0] dh_q, dh_d, dv_q, dv_d;
  logic dsel_q, dsel_d, loop_q, loop_d, stop_q, stop_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d, found_q, found_d;
  logic [8:0] hit_x_q, hit_x_d, hit_y_q, hit_y_d;

  logic [14:0] ang_w, ang_s, ref1, ref2;
  logic a_down, a_left, a_hoff, a_voff;
  logic signed [CW-1:0] pxw, pyw, hy_new, yo_h, vx_new, xo_v, sel_x, sel_y, dxs, dys;
  logic signed [CW-1:0] dxm, dym, hstep, vdy_w, yo_v, xo_h;
  logic signed [CW-1:0] hxn, hyn, vxn, vyn, pick_x, pick_y;
  logic [31+TILE_SHIFT:0] tq_sh;
  logic [grwi_pkg::SQ_W-1:0] sq_sum;
  logic h_lt, v_lt, solid_h, solid_v, solid_p;

  function automatic logic in_map(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
    logic signed [CW-1:0] col;
    logic signed [CW-1:0] row;
    col = x >>> TILE_SHIFT;
    row = y >>> TILE_SHIFT;
    return !x[CW-1] && !y[CW-1] && ($unsigned(col) < CW'(MAP_SIDE))
           && ($unsigned(row) < CW'(MAP_SIDE));
  endfunction

  function automatic logic is_solid(input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y,
                                    input logic [63:0] m);
    logic [5:0] idx;
    idx = 6'(6'(y >>> TILE_SHIFT) * 6'(MAP_SIDE) + 6'(x >>> TILE_SHIFT));
    return !in_map(x, y) || !m[idx];
  endfunction

  function automatic logic [8:0] clamp_out(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    if (v[CW-1]) begin
      r = '0;
    end else if (v > HI_C) begin
      r = HI_C;
    end else begin
      r = v;
    end
    return r[8:0];
  endfunction

  grwi_step_unit u_step (
    .op_i   (unit_op),
    .iter_i (cnt_q[4:0]),
    .cur_i  (unit_in),
    .nxt_o  (unit_out)
  );

  // Angle decode of the incoming item.
  always_comb begin
    ang_w = (ray_angle_i >= grwi_pkg::FULL_TURN) ? ray_angle_i - grwi_pkg::FULL_TURN
                                                 : ray_angle_i;
    if (ang_w >= grwi_pkg::ANG_270 - grwi_pkg::SNAP_TOL &&
        ang_w <= grwi_pkg::ANG_270 + grwi_pkg::SNAP_TOL) begin
      ang_s = grwi_pkg::ANG_270;
    end else if (ang_w >= grwi_pkg::ANG_90 - grwi_pkg::SNAP_TOL &&
                 ang_w <= grwi_pkg::ANG_90 + grwi_pkg::SNAP_TOL) begin
      ang_s = grwi_pkg::ANG_90;
    end else if (ang_w >= grwi_pkg::ANG_180 - grwi_pkg::SNAP_TOL &&
                 ang_w <= grwi_pkg::ANG_180 + grwi_pkg::SNAP_TOL) begin
      ang_s = grwi_pkg::ANG_180;
    end else if (ang_w <= grwi_pkg::SNAP_TOL ||
                 ang_w >= grwi_pkg::FULL_TURN - grwi_pkg::SNAP_TOL) begin
      ang_s = '0;
    end else begin
      ang_s = ang_w;
    end
    a_down = ang_s > grwi_pkg::ANG_180;
    a_left = ang_s > grwi_pkg::ANG_90 && ang_s < grwi_pkg::ANG_270;
    a_hoff = ang_s == '0 || ang_s == grwi_pkg::ANG_180;
    a_voff = ang_s == grwi_pkg::ANG_90 || ang_s == grwi_pkg::ANG_270;
    ref1   = (ang_s >= grwi_pkg::ANG_180) ? ang_s - grwi_pkg::ANG_180 : ang_s;
    ref2   = (ref1 > grwi_pkg::ANG_90) ? grwi_pkg::ANG_180 - ref1 : ref1;
  end

  // Geometry helpers shared by the sequencer states.
  always_comb begin
    pxw    = $signed(CW'(px_q));
    pyw    = $signed(CW'(py_q));
    hy_new = ((pyw >>> TILE_SHIFT) <<< TILE_SHIFT) + (down_q ? TILE_C : NEG_ONE);
    yo_h   = down_q ? hy_new - pyw : pyw - hy_new;
    vx_new = ((pxw >>> TILE_SHIFT) <<< TILE_SHIFT) + (left_q ? NEG_ONE : TILE_C);
    xo_v   = left_q ? pxw - vx_new : vx_new - pxw;
    xo_h   = $signed(ws_q.b[CW-1:0]);
    yo_v   = $signed(ws_q.a[16 +: CW]);
    tq_sh  = {tq_q, {TILE_SHIFT{1'b0}}};
    vdy_w  = $signed(CW'(tq_sh >> 16));
    hstep  = $signed(hdx_q);
    sel_x  = dsel_q ? vx_q : hx_q;
    sel_y  = dsel_q ? vy_q : hy_q;
    dxs    = sel_x - pxw;
    dys    = sel_y - pyw;
    dxm    = dxs[CW-1] ? -dxs : dxs;
    dym    = dys[CW-1] ? -dys : dys;
    h_lt   = hoff_q ? 1'b0 : (voff_q ? 1'b1 : (dh_q < dv_q));
    v_lt   = voff_q ? 1'b0 : (hoff_q ? 1'b1 : (dv_q < dh_q));
    solid_h = is_solid(hx_q, hy_q, open_map_q);
    solid_v = is_solid(vx_q, vy_q, open_map_q);
    pick_x  = h_lt ? hx_q : vx_q;
    pick_y  = h_lt ? hy_q : vy_q;
    solid_p = is_solid(pick_x, pick_y, open_map_q);
    sq_sum  = sq_q + unit_out.a[grwi_pkg::SQ_W-1:0];
  end

  // Step unit operand selection.
  always_comb begin
    unit_in = ws_q;
    unique case (state_q)
      S_CORD:                  unit_op = grwi_pkg::OP_CORDIC;
      S_TDIV, S_HDIV, S_HDXD:  unit_op = grwi_pkg::OP_DIV;
      S_DSQRT:                 unit_op = grwi_pkg::OP_SQRT;
      default:                 unit_op = grwi_pkg::OP_MUL;
    endcase
    unique case (state_q)
      S_VMUL: begin
        unit_in.a = WW'($unsigned(xo_v));
        unit_in.b = WW'(tq_q);
      end
      S_DSQX: begin
        unit_in.a = WW'($unsigned(dxm));
        unit_in.b = WW'($unsigned(dxm));
      end
      S_DSQY: begin
        unit_in.a = WW'($unsigned(dym));
        unit_in.b = WW'($unsigned(dym));
      end
      default: unit_in = ws_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ws_d    = ws_q;
    px_d    = px_q;
    py_d    = py_q;
    down_d  = down_q;
    left_d  = left_q;
    hoff_d  = hoff_q;
    voff_d  = voff_q;
    tq_d    = tq_q;
    hx_d    = hx_q;
    hy_d    = hy_q;
    vx_d    = vx_q;
    vy_d    = vy_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    hdx_d   = hdx_q;
    sq_d    = sq_q;
    dh_d    = dh_q;
    dv_d    = dv_q;
    dsel_d  = dsel_q;
    loop_d  = loop_q;
    stop_d  = stop_q;
    step_d  = step_q;
    hit_x_d = hit_x_q;
    hit_y_d = hit_y_q;
    found_d = found_q;
    hxn     = hx_q;
    hyn     = hy_q;
    vxn     = vx_q;
    vyn     = vy_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          px_d   = player_x_i;
          py_d   = player_y_i;
          down_d = a_down;
          left_d = a_left;
          hoff_d = a_hoff;
          voff_d = a_voff;
          cnt_d  = '0;
          ws_d.a = WW'(1) << 30;
          ws_d.b = '0;
          ws_d.c = WW'(ref2) << 8;
          if (a_hoff) begin
            tq_d    = '0;
            state_d = S_HX;
          end else if (a_voff) begin
            tq_d    = '1;
            state_d = S_HX;
          end else begin
            state_d = S_CORD;
          end
        end
      end
      S_CORD: begin
        ws_d  = unit_out;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CORD_LAST) begin
          state_d = S_TCHK;
        end
      end
      S_TCHK: begin
        if (ws_q.b[WW-1] || ws_q.b == '0) begin
          tq_d    = '0;
          state_d = S_HX;
        end else if (ws_q.a[WW-1] || ws_q.a == '0) begin
          tq_d    = '1;
          state_d = S_HX;
        end else begin
          ws_d.a  = '0;
          ws_d.b  = WW'(ws_q.b[31:0]) << 16;
          ws_d.c  = WW'(ws_q.a[31:0]);
          cnt_d   = '0;
          state_d = S_TDIV;
        end
      end
      S_TDIV, S_HDIV, S_HDXD: begin
        ws_d  = unit_out;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          if (state_q == S_TDIV) begin
            state_d = S_TSAT;
          end else if (state_q == S_HDIV) begin
            state_d = S_VMUL;
          end else begin
            state_d = S_HDXF;
          end
        end
      end
      S_TSAT: begin
        tq_d    = (|ws_q.b[WW-1:32]) ? '1 : ws_q.b[31:0];
        state_d = S_HX;
      end
      S_HX: begin
        hy_d   = hy_new;
        ws_d.a = '0;
        ws_d.c = WW'(tq_q);
        cnt_d  = '0;
        if (voff_q || tq_q == '0) begin
          ws_d.b  = '0;
          state_d = S_VMUL;
        end else begin
          ws_d.b  = WW'($unsigned(yo_h)) << 16;
          state_d = S_HDIV;
        end
      end
      S_VMUL: begin
        hx_d = left_q ? pxw - xo_h : pxw + xo_h;
        vx_d = vx_new;
        ws_d = unit_out;
        if (hoff_q) begin
          ws_d.a = '0;
        end
        state_d = S_VYS;
      end
      S_VYS: begin
        vy_d    = down_q ? pyw + yo_v : pyw - yo_v;
        state_d = S_HDXS;
      end
      S_HDXS: begin
        ws_d.a = '0;
        ws_d.c = WW'(tq_q);
        cnt_d  = '0;
        if (tq_q == '0) begin
          ws_d.b  = '0;
          state_d = S_HDXF;
        end else begin
          ws_d.b  = WW'(1) << (TILE_SHIFT + 16);
          state_d = S_HDXD;
        end
      end
      S_HDXF: begin
        hdx_d   = ws_q.b[CW-1:0];
        dsel_d  = 1'b0;
        loop_d  = 1'b0;
        state_d = S_DSTART;
      end
      S_DSTART: begin
        if (!dsel_q && hoff_q) begin
          dsel_d = 1'b1;
        end else if (dsel_q && voff_q) begin
          state_d = loop_q ? S_PICK : S_FIRST;
        end else begin
          state_d = S_DSQX;
        end
      end
      S_DSQX: begin
        sq_d    = unit_out.a[grwi_pkg::SQ_W-1:0];
        state_d = S_DSQY;
      end
      S_DSQY: begin
        ws_d.a  = '0;
        ws_d.b  = {sq_sum, {(WW - grwi_pkg::SQ_W){1'b0}}};
        ws_d.c  = '0;
        cnt_d   = '0;
        state_d = S_DSQRT;
      end
      S_DSQRT: begin
        ws_d  = unit_out;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SQRT_LAST) begin
          if (dsel_q) begin
            dv_d    = unit_out.c[grwi_pkg::DIST_W-1:0];
            state_d = loop_q ? S_PICK : S_FIRST;
          end else begin
            dh_d    = unit_out.c[grwi_pkg::DIST_W-1:0];
            dsel_d  = 1'b1;
            state_d = S_DSTART;
          end
        end
      end
      S_FIRST: begin
        if (!hoff_q && h_lt && solid_h) begin
          cx_d    = hx_q;
          cy_d    = hy_q;
          stop_d  = 1'b1;
          state_d = S_OUT;
        end else if (!voff_q && v_lt && solid_v) begin
          cx_d    = vx_q;
          cy_d    = vy_q;
          stop_d  = 1'b1;
          state_d = S_OUT;
        end else begin
          cx_d    = vx_q;
          cy_d    = vy_q;
          stop_d  = 1'b0;
          step_d  = '0;
          loop_d  = 1'b1;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (!hoff_q && !solid_h) begin
          hxn = hx_q + (left_q ? -hstep : hstep);
          hyn = hy_q + (down_q ? TILE_C : -TILE_C);
        end
        if (!voff_q && !solid_v) begin
          vxn = vx_q + (left_q ? -TILE_C : TILE_C);
          vyn = vy_q + (down_q ? vdy_w : -vdy_w);
        end
        hx_d    = hxn[CW-1] ? '0 : hxn;
        hy_d    = hyn[CW-1] ? '0 : hyn;
        vx_d    = vxn[CW-1] ? '0 : vxn;
        vy_d    = vyn[CW-1] ? '0 : vyn;
        dsel_d  = 1'b0;
        state_d = S_DSTART;
      end
      S_PICK: begin
        cx_d = pick_x;
        cy_d = pick_y;
        if (solid_p) begin
          stop_d  = 1'b1;
          state_d = S_OUT;
        end else if (step_q == LAST_STEP) begin
          stop_d  = 1'b0;
          state_d = S_OUT;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = S_STEP;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          hit_x_d     = clamp_out(cx_q);
          hit_y_d     = clamp_out(cy_q);
          found_d     = stop_q && in_map(cx_q, cy_q);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      open_map_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        open_map_q <= open_map_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    ws_q    <= ws_d;
    px_q    <= px_d;
    py_q    <= py_d;
    down_q  <= down_d;
    left_q  <= left_d;
    hoff_q  <= hoff_d;
    voff_q  <= voff_d;
    tq_q    <= tq_d;
    hx_q    <= hx_d;
    hy_q    <= hy_d;
    vx_q    <= vx_d;
    vy_q    <= vy_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    hdx_q   <= hdx_d;
    sq_q    <= sq_d;
    dh_q    <= dh_d;
    dv_q    <= dv_d;
    dsel_q  <= dsel_d;
    loop_q  <= loop_d;
    stop_q  <= stop_d;
    step_q  <= step_d;
    hit_x_q <= hit_x_d;
    hit_y_q <= hit_y_d;
    found_q <= found_d;
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign hit_x_o      = hit_x_q;
  assign hit_y_o      = hit_y_q;
  assign wall_found_o = found_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("Sequencer state is not one-hot.");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Block accepted a second transfer without finishing the first.");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PICK) |-> (step_q <= LAST_STEP))
    else $error("Tile step counter passed the step limit.");

  a_cordic_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORD) |-> (cnt_q <= CORD_LAST))
    else $error("CORDIC iteration counter ran past its last rotation.");

  a_hit_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wall_found_o |-> (hit_x_o <= 9'(HI)) && (hit_y_o <= 9'(HI)))
    else $error("Reported wall hit lies outside the map.");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for grid_ray_wall_intersection with a built-in ray predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TILE_SHIFT = 6;
  localparam int MAP_SIDE   = 8;
  localparam int MAX_STEPS  = 16;
  localparam longint TILE   = 64'd1 << TILE_SHIFT;
  localparam longint unsigned DIST_INF = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint unsigned TAN_SAT  = 64'hFFFF_FFFF;
  localparam int IDLE_LIMIT = 30000;
  localparam int RANDOM_RAYS = 450;

  typedef struct packed {
    logic [8:0] hit_x;
    logic [8:0] hit_y;
    logic       wall_found;
  } ray_hit_t;

  typedef struct {
    logic [63:0] map;
    int          px;
    int          py;
    int          ang;
    bit          typed;
    ray_hit_t    hit;
  } ray_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [63:0] open_map_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [8:0]  player_x_i = '0;
  logic [8:0]  player_y_i = '0;
  logic [14:0] ray_angle_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [8:0]  hit_x_o;
  logic [8:0]  hit_y_o;
  logic        wall_found_o;

  ray_hit_t    pending_hits[$];
  logic [63:0] cur_map = '0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          stim_done = 1'b0;

  grid_ray_wall_intersection #(
    .TILE_SHIFT(TILE_SHIFT),
    .MAP_SIDE  (MAP_SIDE),
    .MAX_STEPS (MAX_STEPS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .open_map_i  (open_map_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .player_x_i  (player_x_i),
    .player_y_i  (player_y_i),
    .ray_angle_i (ray_angle_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_x_o     (hit_x_o),
    .hit_y_o     (hit_y_o),
    .wall_found_o(wall_found_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit in_map(longint x, longint y);
    return x >= 0 && y >= 0 && (x >>> TILE_SHIFT) < MAP_SIDE && (y >>> TILE_SHIFT) < MAP_SIDE;
  endfunction

  function automatic bit is_wall(logic [63:0] map, longint x, longint y);
    int idx;
    if (!in_map(x, y)) return 1'b1;
    idx = int'(((y >>> TILE_SHIFT) * MAP_SIDE + (x >>> TILE_SHIFT)) & 63);
    return !map[idx];
  endfunction

  function automatic longint unsigned ray_dist(longint px, longint py, longint x, longint y);
    longint unsigned dx, dy, v, res, b;
    dx = (x > px) ? x - px : px - x;
    dy = (y > py) ? y - py : py - y;
    v = dx * dx + dy * dy;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [8:0] clamp_coord(longint v);
    if (v < 0) return 9'd0;
    if (v > 511) return 9'd511;
    return v[8:0];
  endfunction

  function automatic ray_hit_t cast_ray(logic [63:0] map, int px_in, int py_in, int ang_in);
    longint px, py, a, r, cx, cy, hx, hy, vx, vy, xo, yo, hdx, hdy, vdx, vdy, cdx, cdy, cz, nx;
    longint unsigned tq, dh, dv, q;
    bit down, left, hor_off, ver_off, stopped, found;
    int i;
    ray_hit_t res;
    px = px_in;
    py = py_in;
    a = ang_in;
    stopped = 1'b0;
    found = 1'b0;
    if (a >= 23040) a = a - 23040;
    if (a >= 17217 && a <= 17343) a = 17280;
    else if (a >= 5697 && a <= 5823) a = 5760;
    else if (a >= 11457 && a <= 11583) a = 11520;
    else if (a <= 63 || a >= 22977) a = 0;
    down = a > 11520;
    left = a > 5760 && a < 17280;
    hor_off = (a == 0 || a == 11520);
    ver_off = (a == 5760 || a == 17280);

    if (hor_off) begin
      tq = 0;
    end else if (ver_off) begin
      tq = TAN_SAT;
    end else begin
      r = a % 11520;
      if (r > 5760) r = 11520 - r;
      cdx = 64'sd1 << 30;
      cdy = 0;
      cz = r * 256;
      for (i = 0; i < 20; i++) begin
        if (cz >= 0) begin
          nx = cdx - (cdy >>> i);
          cdy = cdy + (cdx >>> i);
          cz = cz - longint'(grwi_pkg::atan_rom(i[4:0]));
        end else begin
          nx = cdx + (cdy >>> i);
          cdy = cdy - (cdx >>> i);
          cz = cz + longint'(grwi_pkg::atan_rom(i[4:0]));
        end
        cdx = nx;
      end
      if (cdy <= 0) tq = 0;
      else if (cdx <= 0) tq = TAN_SAT;
      else begin
        q = (longint'(cdy) << 16) / longint'(cdx);
        tq = (q > TAN_SAT) ? TAN_SAT : q;
      end
    end

    hy = ((py >>> TILE_SHIFT) << TILE_SHIFT) + (down ? TILE : -1);
    yo = down ? hy - py : py - hy;
    xo = (ver_off || tq == 0) ? 0 : longint'((longint'(yo) << 16) / tq);
    if (left) xo = -xo;
    hx = px + xo;

    vx = ((px >>> TILE_SHIFT) << TILE_SHIFT) + (left ? -1 : TILE);
    xo = left ? px - vx : vx - px;
    yo = hor_off ? 0 : longint'((longint'(xo) * tq) >> 16);
    if (!down) yo = -yo;
    vy = py + yo;

    hdx = (tq != 0) ? longint'((longint'(TILE) << 16) / tq) : 0;
    if (left) hdx = -hdx;
    hdy = down ? TILE : -TILE;
    vdy = longint'((longint'(TILE) * tq) >> 16);
    if (!down) vdy = -vdy;
    vdx = left ? -TILE : TILE;

    dh = hor_off ? DIST_INF : ray_dist(px, py, hx, hy);
    dv = ver_off ? DIST_INF : ray_dist(px, py, vx, vy);
    cx = vx;
    cy = vy;
    if (!hor_off && dh < dv && is_wall(map, hx, hy)) begin
      cx = hx;
      cy = hy;
      stopped = 1'b1;
    end else if (!ver_off && dv < dh && is_wall(map, vx, vy)) begin
      stopped = 1'b1;
    end

    for (i = 0; !stopped && i < MAX_STEPS; i++) begin
      if (!hor_off && !is_wall(map, hx, hy)) begin
        hx = hx + hdx;
        hy = hy + hdy;
      end
      if (hx < 0) hx = 0;
      if (hy < 0) hy = 0;
      if (!ver_off && !is_wall(map, vx, vy)) begin
        vx = vx + vdx;
        vy = vy + vdy;
      end
      if (vx < 0) vx = 0;
      if (vy < 0) vy = 0;
      dh = hor_off ? DIST_INF : ray_dist(px, py, hx, hy);
      dv = ver_off ? DIST_INF : ray_dist(px, py, vx, vy);
      if (dh < dv) begin
        cx = hx;
        cy = hy;
      end else begin
        cx = vx;
        cy = vy;
      end
      if (is_wall(map, cx, cy)) stopped = 1'b1;
    end

    if (stopped) found = in_map(cx, cy);
    res.hit_x = clamp_coord(cx);
    res.hit_y = clamp_coord(cy);
    res.wall_found = found;
    return res;
  endfunction

  task automatic wait_drained();
    while (pending_hits.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_map(input logic [63:0] m);
    wait_drained();
    cfg_valid_i <= 1'b1;
    open_map_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_map = m;
  endtask

  // Valid stays high after a transfer; the caller lowers it for a gap and after the last ray.
  task automatic send_ray(input int px, input int py, input int ang, input bit typed,
                          input ray_hit_t hit);
    in_valid_i <= 1'b1;
    player_x_i <= px[8:0];
    player_y_i <= py[8:0];
    ray_angle_i <= ang[14:0];
    do @(posedge clk_i); while (!in_ready_o);
    pending_hits.push_back(typed ? hit : cast_ray(cur_map, px, py, ang));
  endtask

  task automatic take_gap(input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    ray_hit_t exp_hit;
    if (out_valid_o && out_ready_i) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: x=%0d y=%0d found=%0d", hit_x_o, hit_y_o, wall_found_o);
      end else begin
        exp_hit = pending_hits.pop_front();
        if (hit_x_o !== exp_hit.hit_x || hit_y_o !== exp_hit.hit_y ||
            wall_found_o !== exp_hit.wall_found) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected x=%0d y=%0d found=%0d, got x=%0d y=%0d found=%0d",
                     exp_hit.hit_x, exp_hit.hit_y, exp_hit.wall_found,
                     hit_x_o, hit_y_o, wall_found_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver alternates between always ready and stretches of heavy or light stalling.
  initial begin
    int ready_pct;
    int hold;
    while (1) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 75;
        2: ready_pct = 30;
        default: ready_pct = 5;
      endcase
      hold = $urandom_range(20, 400);
      repeat (hold) begin
        @(posedge clk_i);
        out_ready_i <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  initial begin
    ray_row_t rows[$];
    ray_row_t row;
    logic [63:0] m;
    int burst;
    int px;
    int py;
    int ang;
    int k;
    ray_hit_t none;

    none = '0;
    row.map = 64'd0;
    row.typed = 1'b1;
    row.px = 100; row.py = 100; row.ang = 0;     row.hit = '{9'd128, 9'd100, 1'b1};
    rows.push_back(row);
    row.ang = 5760;  row.hit = '{9'd100, 9'd63, 1'b1};  rows.push_back(row);
    row.ang = 11520; row.hit = '{9'd63, 9'd100, 1'b1};  rows.push_back(row);
    row.ang = 17280; row.hit = '{9'd100, 9'd128, 1'b1}; rows.push_back(row);
    row.px = 511; row.py = 511; row.ang = 0; row.hit = '{9'd511, 9'd511, 1'b0};
    rows.push_back(row);
    row.px = 0; row.py = 0; row.ang = 11520; row.hit = '{9'd0, 9'd0, 1'b0};
    rows.push_back(row);
    row.map = '1;
    row.typed = 1'b0;
    row.hit = none;
    row.px = 0;   row.py = 0;   row.ang = 0;     rows.push_back(row);
    row.px = 511; row.py = 511; row.ang = 5760;  rows.push_back(row);
    row.px = 256; row.py = 256;
    row.ang = 63;    rows.push_back(row);
    row.ang = 64;    rows.push_back(row);
    row.ang = 5697;  rows.push_back(row);
    row.ang = 5696;  rows.push_back(row);
    row.ang = 5823;  rows.push_back(row);
    row.ang = 5824;  rows.push_back(row);
    row.ang = 11583; rows.push_back(row);
    row.ang = 11584; rows.push_back(row);
    row.ang = 17343; rows.push_back(row);
    row.ang = 17344; rows.push_back(row);
    row.ang = 22977; rows.push_back(row);
    row.ang = 22976; rows.push_back(row);
    row.px = 300; row.py = 200; row.ang = 23039; rows.push_back(row);
    row.ang = 32767; rows.push_back(row);
    row.px = 137; row.py = 411; row.ang = 2880;  rows.push_back(row);
    row.px = 400; row.py = 50;  row.ang = 8640;  rows.push_back(row);
    row.px = 17;  row.py = 300; row.ang = 14400; rows.push_back(row);
    row.map = 64'hAA55_AA55_AA55_AA55;
    row.px = 255; row.py = 255; row.ang = 20160; rows.push_back(row);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_map(64'd0);
    foreach (rows[k]) begin
      if (rows[k].map !== cur_map) begin
        take_gap(1);
        write_map(rows[k].map);
      end
      send_ray(rows[k].px, rows[k].py, rows[k].ang, rows[k].typed, rows[k].hit);
      take_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 40));
    end

    k = 0;
    while (k < RANDOM_RAYS) begin
      if (k % 90 == 0) begin
        take_gap(1);
        case ((k / 90) % 5)
          0: m = {$urandom, $urandom} | {$urandom, $urandom};
          1: m = {$urandom, $urandom};
          2: m = '1;
          3: m = 64'h55AA_55AA_55AA_55AA;
          default: m = ({$urandom, $urandom} | {$urandom, $urandom}) & 64'h7EFF_FFFF_FFFF_FF7E;
        endcase
        write_map(m);
      end
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        px = $urandom_range(0, 511);
        py = $urandom_range(0, 511);
        case ($urandom_range(0, 9))
          0: ang = $urandom_range(23040, 32767);
          1: ang = $urandom_range(0, 3) * 5760 + $urandom_range(0, 160) - 80;
          default: ang = $urandom_range(0, 23039);
        endcase
        if (ang < 0) ang = ang + 23040;
        send_ray(px, py, ang, 1'b0, none);
        k++;
      end
      if ($urandom_range(0, 3) == 0) take_gap(0);
      else take_gap($urandom_range(1, 60));
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (1500) @(posedge clk_i);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
